### rtl/rarm_pkg.sv
// Shared constants and types for the range-assign / range-minimum store.
// No dependencies.
package rarm_pkg;

  localparam int ELEMENTS     = 4096;
  localparam int BUCKET_SIZE  = 64;
  localparam int BUCKET_COUNT = 64;

  localparam int IDX_W      = 12;   // width of the range fields
  localparam int VAL_W      = 31;
  localparam int STORE_SIZE = BUCKET_COUNT * BUCKET_SIZE;
  localparam int SA_W       = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int LIM        = (ELEMENTS < STORE_SIZE) ? ELEMENTS : STORE_SIZE;
  // internal index width: holds any field value, the store size and one bucket beyond it
  localparam int XW         = ((SA_W > IDX_W) ? SA_W : IDX_W) + 2;
  localparam int BW         = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  localparam logic [VAL_W-1:0] TOP_VALUE = '1;

  typedef struct packed {
    logic             query;
    logic [XW-1:0]    first;
    logic [XW-1:0]    stop;    // exclusive end, last index clamped
    logic [VAL_W-1:0] value;
    logic             empty;
  } rarm_item_t;

endpackage

### rtl/rarm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rarm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rarm_front.sv
// Front end: accepts items, clamps and classifies the range, two-entry queue.
// Depends on rarm_pkg.
module rarm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_mode,
  input  logic [rarm_pkg::IDX_W-1:0] in_first,
  input  logic [rarm_pkg::IDX_W-1:0] in_last,
  input  logic [rarm_pkg::VAL_W-1:0] in_value,
  output rarm_pkg::rarm_item_t       head,
  output logic                       head_avail,
  input  logic                       head_pop
);
  import rarm_pkg::*;

  rarm_item_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  rarm_item_t cls;
  logic [XW-1:0] last_x, last_c;
  logic push;

  always_comb begin
    last_x = XW'(in_last);
    last_c = (last_x > XW'(LIM - 1)) ? XW'(LIM - 1) : last_x;
    cls.query = in_mode;
    cls.first = XW'(in_first);
    cls.stop  = last_c + XW'(1);
    cls.value = in_value;
    cls.empty = XW'(in_first) > last_c;
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head       = q_r[rp_r];
  assign head_avail = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (head_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, head_pop};
    end
  end

endmodule

### rtl/rarm_back.sv
// Back end: bucket walk sequencer over the element and bucket RAMs, result register.
// Depends on rarm_pkg and rarm_ram.
module rarm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rarm_pkg::rarm_item_t       head,
  input  logic                       head_avail,
  output logic                       head_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rarm_pkg::VAL_W-1:0] out_min
);
  import rarm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BRD, ST_META, ST_FLUSH, ST_PART, ST_AWR, ST_ARD, ST_QRD,
    ST_ADRN, ST_QDRN, ST_NEXT, ST_OUT
  } state_t;

  state_t         state_r;
  rarm_item_t     item_r;
  logic [BW-1:0]  b_r;
  logic [XW-1:0]  l_r, j_r;
  logic [VAL_W-1:0] acc_r, pend_r;
  logic           rdv_r;
  logic [BUCKET_COUNT-1:0] flag_r, valid_r;

  logic [XW-1:0]  r, lo, hi;
  logic           skip, full;
  logic [2*VAL_W-1:0] meta_rd, meta_wd;
  logic           meta_we;
  logic [VAL_W-1:0] meta_min, meta_pend, elem_rd, elem_wd, acc_in;
  logic           elem_we;
  logic           out_load;

  assign r    = l_r + XW'(BUCKET_SIZE);
  assign skip = (r <= item_r.first) || (item_r.stop <= l_r);
  assign full = (item_r.first <= l_r) && (r <= item_r.stop);
  assign lo   = (item_r.first > l_r) ? item_r.first : l_r;
  assign hi   = (item_r.stop < r) ? item_r.stop : r;

  // untouched buckets read as maximum with a pending maximum
  assign meta_min  = valid_r[b_r] ? meta_rd[VAL_W-1:0] : TOP_VALUE;
  assign meta_pend = valid_r[b_r] ? meta_rd[2*VAL_W-1:VAL_W] : TOP_VALUE;
  assign acc_in    = (rdv_r && (elem_rd < acc_r)) ? elem_rd : acc_r;

  // result register free or being emptied this cycle
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid || out_tready);

  always_comb begin
    meta_we = 1'b0;
    meta_wd = {item_r.value, item_r.value};
    elem_we = 1'b0;
    elem_wd = item_r.value;
    case (state_r)
      ST_META: meta_we = full && !item_r.query;
      ST_ADRN: begin
        meta_we = 1'b1;
        meta_wd = {item_r.value, acc_in};
      end
      ST_FLUSH: begin
        elem_we = 1'b1;
        elem_wd = pend_r;
      end
      ST_AWR:  elem_we = 1'b1;
      default: ;
    endcase
  end

  rarm_ram #(.WIDTH(2 * VAL_W), .DEPTH(BUCKET_COUNT)) u_meta (
    .clk(clk), .we(meta_we), .waddr(b_r), .wdata(meta_wd), .raddr(b_r), .rdata(meta_rd)
  );

  rarm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_SIZE)) u_elem (
    .clk(clk), .we(elem_we), .waddr(j_r[SA_W-1:0]), .wdata(elem_wd),
    .raddr(j_r[SA_W-1:0]), .rdata(elem_rd)
  );

  assign head_pop = (state_r == ST_IDLE) && head_avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      flag_r     <= '1;
      valid_r    <= '0;
      rdv_r      <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      rdv_r <= (state_r == ST_ARD) || (state_r == ST_QRD);
      if (out_load) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (head_avail) begin
            item_r <= head;
            acc_r  <= TOP_VALUE;
            b_r    <= '0;
            l_r    <= '0;
            if (head.empty) state_r <= head.query ? ST_OUT : ST_IDLE;
            else            state_r <= ST_BRD;
          end
        end
        ST_BRD: state_r <= skip ? ST_NEXT : ST_META;
        ST_META: begin
          if (full) begin
            if (item_r.query) begin
              if (meta_min < acc_r) acc_r <= meta_min;
            end else begin
              valid_r[b_r] <= 1'b1;
              flag_r[b_r]  <= 1'b1;
            end
            state_r <= ST_NEXT;
          end else if (flag_r[b_r]) begin
            flag_r[b_r] <= 1'b0;
            pend_r      <= meta_pend;
            j_r         <= l_r;
            state_r     <= ST_FLUSH;
          end else begin
            state_r <= ST_PART;
          end
        end
        ST_FLUSH: begin
          j_r <= j_r + XW'(1);
          if (j_r == r - XW'(1)) state_r <= ST_PART;
        end
        ST_PART: begin
          j_r     <= lo;
          state_r <= item_r.query ? ST_QRD : ST_AWR;
        end
        ST_AWR: begin
          if (j_r == hi - XW'(1)) begin
            j_r     <= l_r;
            acc_r   <= TOP_VALUE;
            state_r <= ST_ARD;
          end else begin
            j_r <= j_r + XW'(1);
          end
        end
        ST_ARD: begin
          acc_r <= acc_in;
          j_r   <= j_r + XW'(1);
          if (j_r == r - XW'(1)) state_r <= ST_ADRN;
        end
        ST_QRD: begin
          acc_r <= acc_in;
          j_r   <= j_r + XW'(1);
          if (j_r == hi - XW'(1)) state_r <= ST_QDRN;
        end
        ST_ADRN: begin
          valid_r[b_r] <= 1'b1;
          state_r      <= ST_NEXT;
        end
        ST_QDRN: begin
          acc_r   <= acc_in;
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          if ((b_r == BW'(BUCKET_COUNT - 1)) || (r >= item_r.stop)) begin
            state_r <= item_r.query ? ST_OUT : ST_IDLE;
          end else begin
            b_r     <= b_r + BW'(1);
            l_r     <= r;
            state_r <= ST_BRD;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_min <= acc_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/range_assign_range_min.sv
// Top level of the range-assign / range-minimum store.
// Depends on rarm_pkg, rarm_front, rarm_back.
//
// Keeps 4096 values of 31 bits, all 2^31-1 after reset, in 64 buckets of 64.
// An item either assigns a value to an inclusive index range (no result) or
// asks the minimum over one (one result, 2^31-1 for an empty range). The last
// index is clamped to the array; a reversed range is empty. The front end
// clamps and queues up to two items; the back end walks the buckets from the
// first one up to the end of the range, one per step: a bucket before the
// range is skipped, a fully covered bucket reads the bucket RAM, a partly
// covered one first writes out a pending assignment to all its elements,
// then visits each covered element, and for an assign reads the whole bucket
// again to rebuild the bucket minimum through the single element RAM port.
// No clearing pass is needed after reset: untouched buckets read as holding a
// pending maximum. The result sits in an output register while the next item
// is accepted.
module range_assign_range_min (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // range_first[11:0], range_last[23:12], value[54:24]
  input  logic        in_tuser,   // mode: 0 assign, 1 query
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // minimum[30:0]
);
  import rarm_pkg::*;

  rarm_item_t       head;
  logic             head_avail, head_pop;
  logic [VAL_W-1:0] out_min;

  rarm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_mode(in_tuser),
    .in_first(in_tdata[11:0]), .in_last(in_tdata[23:12]), .in_value(in_tdata[54:24]),
    .head(head), .head_avail(head_avail), .head_pop(head_pop)
  );

  rarm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head(head), .head_avail(head_avail), .head_pop(head_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_min(out_min)
  );

  assign out_tdata = {1'b0, out_min};

endmodule

### dv/range_assign_range_min_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the range-assign / range-minimum store.
// Depends on rarm_pkg and range_assign_range_min; keeps its own flat-array model of the store.

// Holds a flat copy of the array and the minima still owed by the block.
class min_scoreboard;
  logic [rarm_pkg::VAL_W-1:0] cells[rarm_pkg::STORE_SIZE];
  logic [rarm_pkg::VAL_W-1:0] owed_minima[$];
  int errors;

  function new();
    foreach (cells[i]) cells[i] = rarm_pkg::TOP_VALUE;
    errors = 0;
  endfunction

  // Apply one accepted item; a query leaves its expected minimum in the queue.
  function void note_item(bit query, bit [11:0] first, bit [11:0] last,
                          bit [rarm_pkg::VAL_W-1:0] value);
    int stop;
    logic [rarm_pkg::VAL_W-1:0] lowest;
    stop   = (last > rarm_pkg::LIM - 1) ? rarm_pkg::LIM - 1 : last;
    lowest = rarm_pkg::TOP_VALUE;
    for (int j = first; j <= stop; j++) begin
      if (query) begin
        if (cells[j] < lowest) lowest = cells[j];
      end else begin
        cells[j] = value;
      end
    end
    if (query) owed_minima.push_back(lowest);
  endfunction

  function void check_result(logic [31:0] data);
    logic [rarm_pkg::VAL_W-1:0] want;
    if (owed_minima.size() == 0) begin
      $error("unexpected result: minimum %0d", data[30:0]);
      errors++;
    end else begin
      want = owed_minima.pop_front();
      if (data[30:0] !== want) begin
        $error("minimum mismatch: expected %0d, actual %0d", want, data[30:0]);
        errors++;
      end
    end
  endfunction
endclass

module range_assign_range_min_tb;
  import rarm_pkg::*;

  localparam bit MODE_ASSIGN = 1'b0;
  localparam bit MODE_QUERY  = 1'b1;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_START   = 30000;   // receiver cycle at which the long stall begins
  localparam int HOLD_CYCLES  = 6000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // range_first[11:0], range_last[23:12], value[54:24]
  logic        in_tuser = 1'b0; // mode: 0 assign, 1 query
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // minimum[30:0]

  min_scoreboard store_model = new();
  int burst_left;

  always #5 clk = ~clk;

  range_assign_range_min uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Offer one item and wait for the handshake; called at a rising edge.
  // Between bursts valid drops for a random gap in three of four cases.
  task automatic push_item(bit mode, bit [11:0] first, bit [11:0] last, bit [30:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, value, last, first};
    do @(posedge clk); while (!in_tready);
    store_model.note_item(mode, first, last, value);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 600 : 20)) @(posedge clk);
      end
    end
  endtask

  // Random item: mostly ordered ranges of varied length, some reversed,
  // some snapped to bucket edges, some fully random.
  task automatic push_random();
    bit mode;
    bit [11:0] first, last;
    bit [30:0] value;
    int len, sel, end_idx;
    mode = 1'($urandom_range(0, 1));
    sel  = $urandom_range(0, 9);
    first = 12'($urandom_range(0, 4095));
    case (sel)
      0, 1, 2: len = $urandom_range(0, 80);
      3, 4:    len = $urandom_range(0, 4095);
      5: begin
        first = first & ~12'(BUCKET_SIZE - 1);
        len = BUCKET_SIZE * $urandom_range(1, 8) - 1;
      end
      6: len = -int'($urandom_range(1, 200));              // reversed
      default: len = $urandom_range(0, 700);
    endcase
    end_idx = int'(first) + len;
    if (sel == 9) last = 12'($urandom_range(0, 4095));
    else if (end_idx > 4095) last = 12'(4095);
    else if (end_idx < 0) last = 12'(0);
    else last = 12'(end_idx);
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      2:       value = 31'($urandom_range(0, 1000));
      default: value = 31'($urandom());
    endcase
    push_item(mode, first, last, value);
  endtask

  // Stimulus and end of run
  initial begin
    burst_left = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed part
    push_item(MODE_QUERY,  0, 4095, 0);          // untouched store reads the maximum
    push_item(MODE_QUERY,  5, 3, 0);             // reversed range is empty
    push_item(MODE_ASSIGN, 0, 4095, 1000);       // every bucket only pending
    push_item(MODE_QUERY,  10, 20, 0);           // partial bucket writes out pending
    push_item(MODE_ASSIGN, 10, 20, 0);
    push_item(MODE_QUERY,  0, 4095, 0);
    push_item(MODE_ASSIGN, 3000, 2000, 5);       // reversed assign changes nothing
    push_item(MODE_QUERY,  2000, 3000, 0);
    push_item(MODE_ASSIGN, 4095, 4095, '1);
    push_item(MODE_QUERY,  4095, 4095, 0);
    push_item(MODE_ASSIGN, 64, 127, 7);          // exactly one whole bucket
    push_item(MODE_QUERY,  100, 100, 0);
    push_item(MODE_ASSIGN, 0, 0, '1);
    push_item(MODE_QUERY,  0, 63, 0);
    push_item(MODE_QUERY,  4032, 4095, 0);
    push_item(MODE_ASSIGN, 130, 4000, 31'h5555_5555);
    push_item(MODE_QUERY,  129, 131, 0);
    push_item(MODE_ASSIGN, 63, 64, 31'h2AAA_AAAA);
    push_item(MODE_QUERY,  62, 65, 0);
    push_item(MODE_ASSIGN, 0, 4095, '1);
    push_item(MODE_QUERY,  0, 4095, 0);
    push_item(MODE_QUERY,  4095, 0, 0);
    for (int n = 0; n < RANDOM_ITEMS; n++) push_random();
    in_tvalid <= 1'b0;
    while (store_model.owed_minima.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (store_model.owed_minima.size() != 0) begin
      $error("%0d minima never arrived", store_model.owed_minima.size());
      store_model.errors++;
    end
    if (store_model.errors == 0) begin
      $display("** range_assign_range_min: PASSED **");
    end else begin
      $display("** range_assign_range_min: FAILED **");
    end
    $finish;
  end

  // Receiver: checks results and stalls on its own pattern, with one long
  // hold-off so the block backs up and drops in_tready.
  initial begin
    int cycle;
    cycle = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) store_model.check_result(out_tdata);
      cycle++;
      if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
        out_tready <= 1'b0;
      end else begin
        case ((cycle / 500) % 3)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #50000000;
    $display("** range_assign_range_min: FAILED **");
    $finish;
  end

endmodule
